### design/ibfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ibfd_pkg;

    localparam int CH_W   = 4;
    localparam int VAL_W  = 16;
    localparam int DUTY_W = 10;
    localparam int EV_W   = 2;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;

    typedef logic [7:0]        byte_t;
    typedef logic [CH_W-1:0]   chan_t;
    typedef logic [VAL_W-1:0]  value_t;
    typedef logic [DUTY_W-1:0] duty_t;
    typedef logic [EV_W-1:0]   event_t;

    localparam byte_t HDR_FIRST  = 8'h20;
    localparam byte_t HDR_SECOND = 8'h40;

    localparam logic [CIDX_W-1:0] CFG_WATCHED = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_UP      = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_DOWN    = 2'd2;

    localparam chan_t  WATCHED_RESET = 4'd5;
    localparam value_t UP_RESET      = 16'd1000;
    localparam value_t DOWN_RESET    = 16'd2000;

    localparam event_t EV_NONE = 2'd0;
    localparam event_t EV_UP   = 2'd1;
    localparam event_t EV_DOWN = 2'd2;

    localparam value_t SERVO_LO = 16'd1000;
    localparam value_t SERVO_HI = 16'd2000;

    localparam duty_t DUTY_BASE = 10'd499;
    localparam duty_t DUTY_TOP  = 10'd998;

    // Scaled reciprocal of 1000/499: floor(c * 499 / 1000) equals
    // (c * DUTY_MUL) >> DUTY_SHIFT exactly for c in 0..1000.
    localparam int             DUTY_SHIFT = 24;
    localparam int             MUL_W      = 23;
    localparam logic [MUL_W-1:0] DUTY_MUL = 23'd8371832;
    localparam int             PROD_W     = 34;

endpackage

`default_nettype wire

### design/ibfd_duty.sv
`timescale 1ns / 1ps
`default_nettype none

module ibfd_duty (
    input  wire logic            aclk,
    input  wire logic            load,
    input  wire ibfd_pkg::value_t value,
    output ibfd_pkg::duty_t      duty
);
    import ibfd_pkg::*;

    logic [DUTY_W-1:0] ofs_reg;
    logic [DUTY_W-1:0] ofs_next;
    logic [PROD_W-1:0] prod;

    always_comb begin
        if (value < SERVO_LO) begin
            ofs_next = '0;
        end else if (value > SERVO_HI) begin
            ofs_next = DUTY_W'(SERVO_HI - SERVO_LO);
        end else begin
            ofs_next = DUTY_W'(value - SERVO_LO);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ofs_reg <= ofs_next;
        end
    end

    assign prod = PROD_W'(ofs_reg) * PROD_W'(DUTY_MUL);
    assign duty = DUTY_W'(prod >> DUTY_SHIFT) + DUTY_BASE;

endmodule

`default_nettype wire

### design/ibus_frame_to_servo_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Receives an i-Bus byte stream one word per cycle, locks onto the 0x20 0x40
// header and keeps the frame in a small RAM with a registered read; a frame that
// carries the header pair again inside it is dropped. While bytes are coming
// in the block accepts one word every cycle. After the last byte of a clean
// frame it reads each channel back from the RAM as two single-byte reads,
// then clamps and scales it with one multiplier; each channel result steps
// through the states S_LO, S_HI, S_CALC and S_OUT, and the burst of CHANNELS
// results holds off input for its whole run, also while the result side stalls.
// One output register lets the next byte stream start while the final result waits to be taken.
module ibus_frame_to_servo_decoder #(
    parameter int FRAME_BYTES = 32,
    parameter int CHANNELS    = 14
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_wr_en,
    input  wire logic [ibfd_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [ibfd_pkg::CFG_W-1:0]    cfg_wdata,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire ibfd_pkg::byte_t               s_rx_byte,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output ibfd_pkg::chan_t                    m_channel_index,
    output ibfd_pkg::value_t                   m_raw_value,
    output ibfd_pkg::duty_t                    m_servo_duty,
    output ibfd_pkg::event_t                   m_switch_event,
    output logic                               m_last
);
    import ibfd_pkg::*;

    localparam int AW       = $clog2(FRAME_BYTES);
    localparam int IDX_MAX  = (FRAME_BYTES > 2 * CHANNELS + 2) ? FRAME_BYTES
                                                                : 2 * CHANNELS + 2;
    localparam int IDX_W    = $clog2(IDX_MAX + 1);
    localparam int ST_W     = 3;

    localparam logic [ST_W-1:0] S_RX   = 3'd0;
    localparam logic [ST_W-1:0] S_LO   = 3'd1;
    localparam logic [ST_W-1:0] S_HI   = 3'd2;
    localparam logic [ST_W-1:0] S_CALC = 3'd3;
    localparam logic [ST_W-1:0] S_OUT  = 3'd4;

    localparam chan_t     CH_LAST  = CH_W'(CHANNELS);
    localparam logic [AW-1:0] POS_END = AW'(FRAME_BYTES - 1);

    byte_t frame_mem [FRAME_BYTES];

    logic [ST_W-1:0] state_reg, state_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic            hunt_reg, hunt_next;
    logic            emb_reg, emb_next;
    byte_t           prev_byte_reg;
    value_t          prev_watch_reg, prev_watch_next;
    chan_t           ch_reg, ch_next;

    chan_t           watched_reg;
    value_t          up_reg;
    value_t          down_reg;

    logic [IDX_W-1:0] rd_idx;
    logic             rd_ok;
    logic [AW-1:0]    rd_addr;
    byte_t            rd_data_reg;
    logic             rd_ok_reg;

    byte_t            lo_byte_reg;
    value_t           value_reg;
    value_t           value_cur;
    event_t           ev_reg, ev_next;
    duty_t            duty;

    logic             s_fire;
    logic             wr_en;
    logic             out_load;
    logic             emb_hit;

    assign s_ready  = (state_reg == S_RX);
    assign s_fire   = s_valid && s_ready;
    assign wr_en    = s_fire && !hunt_reg;
    assign out_load = (state_reg == S_OUT) && (!m_valid || m_ready);
    assign emb_hit  = (pos_reg >= AW'(3)) && (s_rx_byte == HDR_SECOND)
                      && (prev_byte_reg == HDR_FIRST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            watched_reg <= WATCHED_RESET;
            up_reg      <= UP_RESET;
            down_reg    <= DOWN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WATCHED: watched_reg <= CH_W'(cfg_wdata);
                CFG_UP:      up_reg      <= cfg_wdata;
                CFG_DOWN:    down_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (state_reg)
            S_HI:    rd_idx = IDX_W'({ch_reg, 1'b1});
            default: rd_idx = IDX_W'({ch_reg, 1'b0});
        endcase
        rd_ok   = rd_idx < IDX_W'(FRAME_BYTES);
        rd_addr = rd_ok ? rd_idx[AW-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_mem[pos_reg] <= s_rx_byte;
        end
        rd_data_reg <= frame_mem[rd_addr];
        rd_ok_reg   <= rd_ok;
    end

    assign value_cur = {(rd_ok_reg ? rd_data_reg : 8'h00), lo_byte_reg};

    always_comb begin
        ev_next         = EV_NONE;
        prev_watch_next = prev_watch_reg;
        if (ch_reg == watched_reg) begin
            if (prev_watch_reg != '0 && value_cur != prev_watch_reg) begin
                if (value_cur == up_reg) begin
                    ev_next = EV_UP;
                end else if (value_cur == down_reg) begin
                    ev_next = EV_DOWN;
                end
            end
            prev_watch_next = value_cur;
        end
    end

    ibfd_duty u_duty (
        .aclk  (aclk),
        .load  (state_reg == S_CALC),
        .value (value_cur),
        .duty  (duty)
    );

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        hunt_next  = hunt_reg;
        emb_next   = emb_reg;
        ch_next    = ch_reg;
        case (state_reg)
            S_RX: begin
                if (s_fire) begin
                    if (hunt_reg) begin
                        if (pos_reg == AW'(1) && s_rx_byte == HDR_SECOND) begin
                            pos_next  = AW'(2);
                            hunt_next = 1'b0;
                            emb_next  = 1'b0;
                        end else if (s_rx_byte == HDR_FIRST) begin
                            pos_next = AW'(1);
                        end else begin
                            pos_next = '0;
                        end
                    end else if (pos_reg == POS_END) begin
                        pos_next  = '0;
                        hunt_next = 1'b1;
                        emb_next  = 1'b0;
                        if (!(emb_reg || emb_hit)) begin
                            ch_next    = CH_W'(1);
                            state_next = S_LO;
                        end
                    end else begin
                        pos_next = pos_reg + AW'(1);
                        emb_next = emb_reg || emb_hit;
                    end
                end
            end
            S_LO:   state_next = S_HI;
            S_HI:   state_next = S_CALC;
            S_CALC: state_next = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    if (ch_reg == CH_LAST) begin
                        state_next = S_RX;
                    end else begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = S_LO;
                    end
                end
            end
            default: state_next = S_RX;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_RX;
            pos_reg        <= '0;
            hunt_reg       <= 1'b1;
            emb_reg        <= 1'b0;
            prev_watch_reg <= '0;
            ch_reg         <= CH_W'(1);
            m_valid        <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            hunt_reg  <= hunt_next;
            emb_reg   <= emb_next;
            ch_reg    <= ch_next;
            if (state_reg == S_CALC) begin
                prev_watch_reg <= prev_watch_next;
            end
            if (out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            prev_byte_reg <= s_rx_byte;
        end
        if (state_reg == S_HI) begin
            lo_byte_reg <= rd_ok_reg ? rd_data_reg : 8'h00;
        end
        if (state_reg == S_CALC) begin
            value_reg <= value_cur;
            ev_reg    <= ev_next;
        end
        if (out_load) begin
            m_channel_index <= ch_reg;
            m_raw_value     <= value_reg;
            m_servo_duty    <= duty;
            m_switch_event  <= ev_reg;
            m_last          <= (ch_reg == CH_LAST);
        end
    end

endmodule

`default_nettype wire

### design/ibfd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ibfd_checker #(
    parameter int CHANNELS = 14
) (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire ibfd_pkg::chan_t  m_channel_index,
    input wire ibfd_pkg::value_t m_raw_value,
    input wire ibfd_pkg::duty_t  m_servo_duty,
    input wire ibfd_pkg::event_t m_switch_event,
    input wire logic             m_last
);
    import ibfd_pkg::*;

    // The final word of a frame always carries the highest channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_channel_index == CH_W'(CHANNELS)))
        else $error("last flag on a channel other than the final one");

    // A duty outside the servo range means the scaling went wrong.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_servo_duty >= DUTY_BASE && m_servo_duty <= DUTY_TOP))
        else $error("servo duty out of range");

    // A value at or below the low clamp point gives the lowest duty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_raw_value <= SERVO_LO) |-> (m_servo_duty == DUTY_BASE))
        else $error("low clamp not applied");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_raw_value)
                                   && $stable(m_channel_index)
                                   && $stable(m_switch_event)))
        else $error("stalled result word changed");

endmodule

bind ibus_frame_to_servo_decoder ibfd_checker #(.CHANNELS(CHANNELS)) u_ibfd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_channel_index (m_channel_index),
    .m_raw_value     (m_raw_value),
    .m_servo_duty    (m_servo_duty),
    .m_switch_event  (m_switch_event),
    .m_last          (m_last)
);

`default_nettype wire

### verif/tb_ibus_frame_to_servo_decoder.sv
`timescale 1ns / 1ps

module tb_ibus_frame_to_servo_decoder;
    import ibfd_pkg::*;

    localparam int FRAME_LEN   = 32;
    localparam int NUM_CH      = 14;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 64;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_BYTES = 1;

    typedef struct {
        chan_t  index;
        value_t value;
        duty_t  duty;
        event_t ev;
        logic   last;
    } channel_result_t;

    class channel_scoreboard;
        byte_t           frame[FRAME_LEN];
        int              position;
        bit              hunting;
        bit              embedded;
        value_t          last_watched;
        chan_t           watched_ch;
        value_t          up_value;
        value_t          down_value;
        int              failures;
        channel_result_t expected[$];

        function new();
            position     = 0;
            hunting      = 1'b1;
            embedded     = 1'b0;
            last_watched = '0;
            watched_ch   = WATCHED_RESET;
            up_value     = UP_RESET;
            down_value   = DOWN_RESET;
            failures     = 0;
        endfunction

        function void write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
            case (idx)
                CFG_WATCHED: watched_ch = data[CH_W-1:0];
                CFG_UP:      up_value = data;
                CFG_DOWN:    down_value = data;
                default:     ;
            endcase
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void take_byte(input byte_t b);
            channel_result_t r;
            int unsigned     v;
            int unsigned     clamped;
            int              c;
            if (hunting) begin
                if (position == 1 && b == HDR_SECOND) begin
                    frame[1] = b;
                    position = 2;
                    hunting  = 1'b0;
                    embedded = 1'b0;
                end else if (b == HDR_FIRST) begin
                    frame[0] = b;
                    position = 1;
                end else begin
                    position = 0;
                end
                return;
            end
            frame[position] = b;
            if (position >= 3 && b == HDR_SECOND && frame[position-1] == HDR_FIRST)
                embedded = 1'b1;
            position++;
            if (position < FRAME_LEN)
                return;
            hunting  = 1'b1;
            position = 0;
            if (embedded) begin
                embedded = 1'b0;
                return;
            end
            for (c = 1; c <= NUM_CH; c++) begin
                v       = {frame[2*c+1], frame[2*c]};
                clamped = (v < SERVO_LO) ? SERVO_LO : (v > SERVO_HI) ? SERVO_HI : v;
                r.index = chan_t'(c);
                r.value = value_t'(v);
                r.duty  = duty_t'((clamped - SERVO_LO) * 499 / 1000 + DUTY_BASE);
                r.ev    = EV_NONE;
                if (c == watched_ch) begin
                    if (last_watched != 0 && value_t'(v) != last_watched) begin
                        if (value_t'(v) == up_value)
                            r.ev = EV_UP;
                        else if (value_t'(v) == down_value)
                            r.ev = EV_DOWN;
                    end
                    last_watched = value_t'(v);
                end
                r.last = (c == NUM_CH);
                expected.push_back(r);
            end
        endfunction

        function void check_channel(input chan_t idx, input value_t value, input duty_t duty,
                                    input event_t ev, input logic last);
            channel_result_t want;
            if (expected.size() == 0) begin
                $error("unexpected channel word: index %0d value %0d", idx, value);
                failures++;
                return;
            end
            want = expected.pop_front();
            if (idx !== want.index) begin
                $error("channel_index: expected %0d, got %0d", want.index, idx);
                failures++;
            end
            if (value !== want.value) begin
                $error("raw_value: expected %0d, got %0d", want.value, value);
                failures++;
            end
            if (duty !== want.duty) begin
                $error("servo_duty: expected %0d, got %0d", want.duty, duty);
                failures++;
            end
            if (ev !== want.ev) begin
                $error("switch_event: expected %0d, got %0d", want.ev, ev);
                failures++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, last);
                failures++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CIDX_W-1:0] cfg_index = CFG_WATCHED;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    byte_t             s_rx_byte = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    chan_t             m_channel_index;
    value_t            m_raw_value;
    duty_t             m_servo_duty;
    event_t            m_switch_event;
    logic              m_last;
    bit                hold_request = 1'b0;

    channel_scoreboard channels = new();
    value_t            frame_vals[NUM_CH];
    byte_t             outgoing[$];

    ibus_frame_to_servo_decoder #(
        .FRAME_BYTES(FRAME_LEN),
        .CHANNELS(NUM_CH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_channel_index(m_channel_index),
        .m_raw_value(m_raw_value),
        .m_servo_duty(m_servo_duty),
        .m_switch_event(m_switch_event),
        .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int pause_length(input bit fluent);
        int r;
        if (fluent)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic value_t pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return value_t'($urandom);
        if (r < 25)
            return (r < 20) ? 16'd0 : 16'hFFFF;
        if (r < 70)
            return value_t'($urandom_range(1000, 2000));
        if (r < 78)
            return value_t'($urandom_range(985, 1015));
        if (r < 85)
            return value_t'($urandom_range(1985, 2015));
        return value_t'($urandom_range(0, 3000));
    endfunction

    // The watched channel mostly carries the switch values so that events occur.
    function automatic void fill_random_values();
        int c;
        int r;
        for (c = 0; c < NUM_CH; c++)
            frame_vals[c] = pick_value();
        if (channels.watched_ch >= 1 && channels.watched_ch <= NUM_CH) begin
            r = $urandom_range(0, 99);
            c = channels.watched_ch - 1;
            if (r < 35)
                frame_vals[c] = channels.up_value;
            else if (r < 70)
                frame_vals[c] = channels.down_value;
            else if (r < 82)
                frame_vals[c] = channels.last_watched;
        end
    endfunction

    function automatic void push_frame(input byte_t ck_lo, input byte_t ck_hi);
        int c;
        outgoing.push_back(HDR_FIRST);
        outgoing.push_back(HDR_SECOND);
        for (c = 0; c < NUM_CH; c++) begin
            outgoing.push_back(frame_vals[c][7:0]);
            outgoing.push_back(frame_vals[c][15:8]);
        end
        outgoing.push_back(ck_lo);
        outgoing.push_back(ck_hi);
    endfunction

    task automatic send_byte(input byte_t b, input bit fluent);
        int gap;
        gap = pause_length(fluent);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        channels.take_byte(b);
    endtask

    task automatic send_outgoing();
        bit fluent;
        fluent = ($urandom_range(0, 3) == 0);
        while (outgoing.size() > 0)
            send_byte(outgoing.pop_front(), fluent);
    endtask

    task automatic load_settings(input chan_t watch, input value_t up, input value_t down);
        logic [CFG_W-CH_W-1:0] upper;
        upper = (CFG_W-CH_W)'($urandom_range(0, 4095));
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_WATCHED;
        cfg_wdata <= {upper, watch};
        @(posedge aclk);
        channels.write_reg(CFG_WATCHED, {upper, watch});
        cfg_index <= CFG_UP;
        cfg_wdata <= up;
        @(posedge aclk);
        channels.write_reg(CFG_UP, up);
        cfg_index <= CFG_DOWN;
        cfg_wdata <= down;
        @(posedge aclk);
        channels.write_reg(CFG_DOWN, down);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (channels.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic directed_frames();
        // Noise, a header byte followed by junk, then a doubled first header byte.
        outgoing = '{8'h00, 8'hFF, HDR_SECOND, HDR_FIRST, 8'h7E, HDR_FIRST};
        frame_vals = '{16'd0, 16'hFFFF, 16'd999, 16'd1000, 16'd1500, 16'd2000, 16'd2001,
                       16'd1001, 16'd1999, 16'd1234, 16'd1500, 16'h8000, 16'd5, 16'hFFFE};
        push_frame(8'h55, 8'hAA);
        fill_random_values();
        frame_vals[4] = UP_RESET;
        outgoing.push_back(HDR_FIRST);
        outgoing.push_back(8'h33);
        push_frame(byte_t'($urandom), byte_t'($urandom));
        // Both rejected frames carry the header pair inside, at the first and the
        // last place it can sit; neither may update the watched channel history.
        fill_random_values();
        frame_vals[0] = 16'h4020;
        frame_vals[4] = DOWN_RESET;
        push_frame(byte_t'($urandom), byte_t'($urandom));
        fill_random_values();
        frame_vals[4] = DOWN_RESET;
        push_frame(HDR_FIRST, HDR_SECOND);
        fill_random_values();
        frame_vals[4] = DOWN_RESET;
        push_frame(byte_t'($urandom), byte_t'($urandom));
        send_outgoing();
    endtask

    task automatic random_traffic(input int n_bytes);
        int sent;
        int r;
        int k;
        sent = 0;
        while (sent < n_bytes) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                fill_random_values();
                push_frame(byte_t'($urandom), byte_t'($urandom));
                if (r >= 68) begin
                    k = $urandom_range(2, FRAME_LEN - 2);
                    outgoing[k]     = HDR_FIRST;
                    outgoing[k + 1] = HDR_SECOND;
                end
            end else if (r < 92) begin
                repeat ($urandom_range(1, 6)) begin
                    k = $urandom_range(0, 3);
                    outgoing.push_back(k == 0 ? HDR_FIRST :
                                       k == 1 ? HDR_SECOND : byte_t'($urandom));
                end
            end else begin
                outgoing.push_back(HDR_FIRST);
                outgoing.push_back(HDR_SECOND);
                repeat ($urandom_range(1, FRAME_LEN - 3))
                    outgoing.push_back(byte_t'($urandom));
            end
            sent += outgoing.size();
            send_outgoing();
        end
    endtask

    initial begin : result_sink
        int stall;
        int fluent;
        fluent = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                channels.check_channel(m_channel_index, m_raw_value, m_servo_duty,
                                       m_switch_event, m_last);
            if (hold_request) begin
                hold_request <= 1'b0;
                m_ready      <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (fluent > 0) begin
                fluent--;
                m_ready <= 1'b1;
            end else begin
                if ($urandom_range(0, 19) == 0)
                    fluent = $urandom_range(20, 80);
                stall = pause_length(1'b0);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_ibus_frame_to_servo_decoder: errors");
        $finish;
    end

    initial begin : stimulus
        value_t v;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        hold_request <= 1'b1;
        directed_frames();
        settle();

        load_settings(4'd1, 16'd0, 16'hFFFF);
        random_traffic(PHASE_BYTES);
        settle();

        load_settings(4'd14, 16'hFFFF, 16'd0);
        random_traffic(PHASE_BYTES);
        settle();

        v = value_t'($urandom_range(990, 2010));
        load_settings(chan_t'($urandom_range(1, NUM_CH)), v, v);
        random_traffic(PHASE_BYTES);
        settle();

        load_settings(chan_t'($urandom_range(1, NUM_CH)), value_t'($urandom),
                      value_t'($urandom));
        random_traffic(PHASE_BYTES);
        settle();

        load_settings(WATCHED_RESET, UP_RESET, DOWN_RESET);
        random_traffic(PHASE_BYTES);
        settle();

        if (channels.failures == 0)
            $display("tb_ibus_frame_to_servo_decoder: clean");
        else
            $display("tb_ibus_frame_to_servo_decoder: errors");
        $finish;
    end

endmodule

### filelist.f
design/ibfd_pkg.sv
design/ibfd_duty.sv
design/ibus_frame_to_servo_decoder.sv
design/ibfd_checker.sv
verif/tb_ibus_frame_to_servo_decoder.sv
